>>> rtl/ordered_list_engine_macros.svh
// Assertion macros shared by the ordered list engine RTL.
// Each macro expects clk and rst to be visible in the enclosing module.
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define OLL_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define OLL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/oll_pkg.sv
// Package for the ordered list engine: sizes, command and status codes,
// cell operation type and value conversion functions. No dependencies.
package oll_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CMP_W      = (CNT_W > 5) ? CNT_W : 5;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;

  localparam logic [2:0] CMD_ADD_FRONT = 3'd0;
  localparam logic [2:0] CMD_ADD_BACK  = 3'd1;
  localparam logic [2:0] CMD_INSERT    = 3'd2;
  localparam logic [2:0] CMD_DELETE    = 3'd3;
  localparam logic [2:0] CMD_LIST      = 3'd4;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_POS     = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  typedef enum logic [2:0] {
    CELL_KEEP,
    CELL_NEW,
    CELL_LEFT,
    CELL_RIGHT,
    CELL_HEAD
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  function automatic data_t to_stored(logic signed [31:0] v);
    return data_t'(v);
  endfunction

  function automatic logic signed [31:0] to_output(data_t d);
    return 32'(signed'(d));
  endfunction

endpackage

>>> rtl/ordered_list_engine.sv
// Top level of the ordered list engine: a chain of entry cells under a
// command sequencer. Depends on oll_pkg, oll_cell and oll_ctrl.
//
// Usage:
//   Command channel: drive cmd, value and position with start high; the word
//   is taken at a rising edge where start is high and busy is low.
//   Result channel: each result word sits on status, value_out, count and
//   last for one cycle with strobe high. The receiver cannot stall; it must
//   take every strobed word.
// Timing:
//   Add front, add back and insert finish in the accepting cycle; the single
//   result word is strobed in the cycle after and busy stays low, so they may follow
//   every cycle.
//   Delete and list rotate the chain once per entry while busy is high
//   (N = entries at the start, at most 16); a command is taken again once
//   busy is low. List strobes N words from the head cell, one per cycle,
//   last on the final one; delete strobes one word, after the last
//   rotation. Empty: a single word, and busy stays low.
//   Unused command codes are accepted and give no result.
// Reset: rst, synchronous, empties the list and drops any run in flight.
module ordered_list_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] value,
  input  logic [4:0]         position,
  output logic               busy,
  output logic               strobe,
  output logic [2:0]         status,
  output logic signed [31:0] value_out,
  output logic [4:0]         count,
  output logic               last
);

  oll_pkg::cell_op_t cell_op [oll_pkg::CAPACITY];
  oll_pkg::data_t    cell_data [oll_pkg::CAPACITY];
  oll_pkg::data_t    new_data;
  oll_pkg::cnt_t     count_int;

  assign count = 5'(count_int);

  oll_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .value     (value),
    .position  (position),
    .head_data (cell_data[0]),
    .busy      (busy),
    .cell_op   (cell_op),
    .new_data  (new_data),
    .strobe    (strobe),
    .status    (status),
    .value_out (value_out),
    .count     (count_int),
    .last      (last)
  );

  for (genvar g = 0; g < oll_pkg::CAPACITY; g++) begin : g_cell
    oll_pkg::data_t left_data;
    oll_pkg::data_t right_data;

    if (g == 0) begin : g_first
      assign left_data = cell_data[g];
    end else begin : g_inner_left
      assign left_data = cell_data[g-1];
    end

    if (g == oll_pkg::CAPACITY - 1) begin : g_end
      assign right_data = cell_data[g];
    end else begin : g_inner_right
      assign right_data = cell_data[g+1];
    end

    oll_cell u_cell (
      .clk        (clk),
      .op         (cell_op[g]),
      .new_data   (new_data),
      .left_data  (left_data),
      .right_data (right_data),
      .head_data  (cell_data[0]),
      .data       (cell_data[g])
    );
  end

endmodule

>>> rtl/oll_cell.sv
// One storage cell of the ordered list chain: holds a single entry and
// loads it from the new word, from a neighbor or from the head cell. Depends on oll_pkg.
module oll_cell (
  input  logic              clk,
  input  oll_pkg::cell_op_t op,
  input  oll_pkg::data_t    new_data,
  input  oll_pkg::data_t    left_data,
  input  oll_pkg::data_t    right_data,
  input  oll_pkg::data_t    head_data,
  output oll_pkg::data_t    data
);

  oll_pkg::data_t data_next;

  always_comb begin
    unique case (op)
      oll_pkg::CELL_KEEP:  data_next = data;
      oll_pkg::CELL_NEW:   data_next = new_data;
      oll_pkg::CELL_LEFT:  data_next = left_data;
      oll_pkg::CELL_RIGHT: data_next = right_data;
      oll_pkg::CELL_HEAD:  data_next = head_data;
      default:             data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

>>> rtl/oll_ctrl.sv
// Command sequencer of the ordered list engine: decodes commands, steers the
// cell chain, counts entries and registers result words. Depends on oll_pkg and the assertion macros header.
`include "ordered_list_engine_macros.svh"

module oll_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [2:0]                          cmd,
  input  logic signed [31:0]                  value,
  input  logic [4:0]                          position,
  input  oll_pkg::data_t                      head_data,
  output logic                                busy,
  output oll_pkg::cell_op_t                   cell_op [oll_pkg::CAPACITY],
  output oll_pkg::data_t                      new_data,
  output logic                                strobe,
  output logic [2:0]                          status,
  output logic signed [31:0]                  value_out,
  output oll_pkg::cnt_t                       count,
  output logic                                last
);

  localparam oll_pkg::cnt_t FULL_COUNT = oll_pkg::CNT_W'(oll_pkg::CAPACITY);

  oll_pkg::state_t    state, state_next;
  oll_pkg::cnt_t      entry_count, entry_count_next;
  oll_pkg::idx_t      step, step_next;
  oll_pkg::idx_t      last_idx, last_idx_next;
  oll_pkg::data_t     key, key_next;
  logic               found, found_next;
  logic               op_list, op_list_next;

  logic               strobe_next;
  logic [2:0]         status_next;
  logic signed [31:0] value_out_next;
  logic               last_next;

  logic               accept;
  logic               cmd_ins;
  logic               full;
  logic               pos_bad;
  logic               head_hit;
  oll_pkg::cnt_t      ins_idx;
  oll_pkg::cnt_t      tail_idx;

  assign busy     = (state == oll_pkg::S_RUN);
  assign accept   = start && (state == oll_pkg::S_IDLE);
  assign cmd_ins  = (cmd == oll_pkg::CMD_ADD_FRONT) || (cmd == oll_pkg::CMD_ADD_BACK) ||
                    (cmd == oll_pkg::CMD_INSERT);
  assign full     = (entry_count == FULL_COUNT);
  assign pos_bad  = (cmd == oll_pkg::CMD_INSERT) &&
                    (oll_pkg::CMP_W'(position) > oll_pkg::CMP_W'(entry_count));
  assign head_hit = (head_data == key);
  assign tail_idx = entry_count - oll_pkg::CNT_W'(1);
  assign new_data = oll_pkg::to_stored(value);

  always_comb begin
    priority if (cmd == oll_pkg::CMD_ADD_FRONT) begin
      ins_idx = '0;
    end else if (cmd == oll_pkg::CMD_ADD_BACK) begin
      ins_idx = entry_count;
    end else begin
      // position is known to be no larger than the count when used
      ins_idx = oll_pkg::CNT_W'(position);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= oll_pkg::S_IDLE;
      entry_count <= '0;
      strobe      <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      strobe      <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    step      <= step_next;
    last_idx  <= last_idx_next;
    key       <= key_next;
    found     <= found_next;
    op_list   <= op_list_next;
    status    <= status_next;
    value_out <= value_out_next;
    count     <= entry_count_next;
    last      <= last_next;
  end

  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    step_next        = step;
    last_idx_next    = last_idx;
    key_next         = key;
    found_next       = found;
    op_list_next     = op_list;
    strobe_next      = 1'b0;
    status_next      = oll_pkg::ST_DONE;
    value_out_next   = '0;
    last_next        = 1'b1;
    for (int i = 0; i < oll_pkg::CAPACITY; i++) begin
      cell_op[i] = oll_pkg::CELL_KEEP;
    end

    unique case (state)
      oll_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd_ins) begin
            strobe_next = 1'b1;
            priority if (full) begin
              status_next = oll_pkg::ST_FULL;
            end else if (pos_bad) begin
              status_next = oll_pkg::ST_POS;
            end else begin
              // open a gap at the insert point: cells past it take from the left
              for (int i = 0; i < oll_pkg::CAPACITY; i++) begin
                if (oll_pkg::CNT_W'(i) > ins_idx) begin
                  cell_op[i] = oll_pkg::CELL_LEFT;
                end else if (oll_pkg::CNT_W'(i) == ins_idx) begin
                  cell_op[i] = oll_pkg::CELL_NEW;
                end
              end
              entry_count_next = entry_count + oll_pkg::CNT_W'(1);
            end
          end else if ((cmd == oll_pkg::CMD_DELETE) || (cmd == oll_pkg::CMD_LIST)) begin
            if (entry_count == '0) begin
              strobe_next = 1'b1;
              status_next = (cmd == oll_pkg::CMD_LIST) ? oll_pkg::ST_EMPTY
                                                       : oll_pkg::ST_MISSING;
            end else begin
              state_next    = oll_pkg::S_RUN;
              step_next     = '0;
              last_idx_next = oll_pkg::IDX_W'(tail_idx);
              key_next      = oll_pkg::to_stored(value);
              found_next    = 1'b0;
              op_list_next  = (cmd == oll_pkg::CMD_LIST);
            end
          end
        end
      end

      oll_pkg::S_RUN: begin
        step_next = step + oll_pkg::IDX_W'(1);
        if (!op_list && !found && head_hit) begin
          // drop the head: close the ring over it and shorten the list
          for (int i = 0; i < oll_pkg::CAPACITY; i++) begin
            if (oll_pkg::CNT_W'(i) < tail_idx) begin
              cell_op[i] = oll_pkg::CELL_RIGHT;
            end
          end
          entry_count_next = tail_idx;
          found_next       = 1'b1;
        end else begin
          // rotate the valid segment by one: head goes to the tail
          for (int i = 0; i < oll_pkg::CAPACITY; i++) begin
            if (oll_pkg::CNT_W'(i) < tail_idx) begin
              cell_op[i] = oll_pkg::CELL_RIGHT;
            end else if (oll_pkg::CNT_W'(i) == tail_idx) begin
              cell_op[i] = oll_pkg::CELL_HEAD;
            end
          end
        end

        if (op_list) begin
          strobe_next    = 1'b1;
          value_out_next = oll_pkg::to_output(head_data);
          last_next      = (step == last_idx);
        end else if (step == last_idx) begin
          strobe_next = 1'b1;
          status_next = (found || head_hit) ? oll_pkg::ST_DONE : oll_pkg::ST_MISSING;
        end

        if (step == last_idx) begin
          state_next = oll_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = oll_pkg::S_IDLE;
      end
    endcase
  end

  `OLL_ASSERT(a_count_bound, entry_count <= FULL_COUNT, "entry count above capacity")
  `OLL_ASSERT(a_run_nonempty, (state != oll_pkg::S_RUN) || (entry_count != '0), "scan on empty list")
  `OLL_ASSERT_NEXT(a_list_contiguous, strobe && !last, strobe, "gap inside a listing run")
  `OLL_ASSERT_NEXT(a_full_reject, accept && cmd_ins && full, strobe && (status == oll_pkg::ST_FULL), "full store not reported")

endmodule

>>> verif/ordered_list_engine_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for ordered_list_engine: directed table, then random
// commands, all checked against a queue-based list predictor. Uses oll_pkg.
module ordered_list_engine_test;

  localparam int LIMIT_CYCLES   = 150000;
  localparam int RAND_PER_PHASE = 80;
  localparam int TAIL_CYCLES    = 40;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] val;
    logic [4:0]  cnt;
    logic        last;
  } list_word_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] val;
    logic [4:0]  pos;
    logic [4:0]  reps;
    logic        typed;
    logic [2:0]  st;
    logic [4:0]  cnt;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic [2:0]         cmd;
  logic signed [31:0] value;
  logic [4:0]         position;
  logic               busy;
  logic               strobe;
  logic [2:0]         status;
  logic signed [31:0] value_out;
  logic [4:0]         count;
  logic               last;

  oll_pkg::data_t held_entries[$];
  list_word_t     awaited_words[$];
  stim_row_t      stim_rows[$];
  list_word_t     exp_word, got_word;
  int unsigned    word_errors = 0;
  int unsigned    cycle_count = 0;
  int             idle_pct;
  bit             filling;

  ordered_list_engine u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .value     (value),
    .position  (position),
    .busy      (busy),
    .strobe    (strobe),
    .status    (status),
    .value_out (value_out),
    .count     (count),
    .last      (last)
  );

  always #4 clk = ~clk;

  // Work out the result words of one accepted command and update the list.
  function automatic void apply_list_cmd(logic [2:0] op, logic [31:0] v, logic [4:0] p);
    oll_pkg::data_t d;
    int             hit;
    d   = oll_pkg::data_t'(v);
    hit = -1;
    case (op)
      oll_pkg::CMD_ADD_FRONT, oll_pkg::CMD_ADD_BACK, oll_pkg::CMD_INSERT: begin
        if (held_entries.size() >= oll_pkg::CAPACITY) begin
          awaited_words.push_back('{oll_pkg::ST_FULL, 32'd0, 5'(held_entries.size()), 1'b1});
        end else if (op == oll_pkg::CMD_INSERT && p > held_entries.size()) begin
          awaited_words.push_back('{oll_pkg::ST_POS, 32'd0, 5'(held_entries.size()), 1'b1});
        end else begin
          if (op == oll_pkg::CMD_ADD_FRONT) held_entries.push_front(d);
          else if (op == oll_pkg::CMD_ADD_BACK) held_entries.push_back(d);
          else held_entries.insert(p, d);
          awaited_words.push_back('{oll_pkg::ST_DONE, 32'd0, 5'(held_entries.size()), 1'b1});
        end
      end
      oll_pkg::CMD_DELETE: begin
        foreach (held_entries[i])
          if (hit < 0 && held_entries[i] == d) hit = i;
        if (hit >= 0) begin
          held_entries.delete(hit);
          awaited_words.push_back('{oll_pkg::ST_DONE, 32'd0, 5'(held_entries.size()), 1'b1});
        end else begin
          awaited_words.push_back('{oll_pkg::ST_MISSING, 32'd0,
                                    5'(held_entries.size()), 1'b1});
        end
      end
      oll_pkg::CMD_LIST: begin
        if (held_entries.size() == 0) begin
          awaited_words.push_back('{oll_pkg::ST_EMPTY, 32'd0, 5'd0, 1'b1});
        end else begin
          foreach (held_entries[i])
            awaited_words.push_back('{oll_pkg::ST_DONE, 32'($signed(held_entries[i])),
                                      5'(held_entries.size()),
                                      i == held_entries.size() - 1});
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_row(logic [2:0] op, logic [31:0] v, logic [4:0] p,
                                  logic [4:0] reps, logic typed, logic [2:0] st,
                                  logic [4:0] cnt);
    stim_rows.push_back('{op, v, p, reps, typed, st, cnt});
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return 32'($urandom_range(6)) - 32'd3;
      4, 5: begin
        if (held_entries.size() != 0)
          return held_entries[$urandom_range(held_entries.size() - 1)];
        return $urandom();
      end
      6: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Hold the word on the ports until taken, then predict it.
  task automatic send_cmd(input logic [2:0] op, input logic [31:0] v, input logic [4:0] p);
    start    <= 1'b1;
    cmd      <= op;
    value    <= v;
    position <= p;
    do @(posedge clk); while (!(start && !busy));
    apply_list_cmd(op, v, p);
  endtask

  task automatic pause_cycle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_words.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      got_word = '{status, value_out, count, last};
      if (awaited_words.size() == 0) begin
        word_errors++;
        $display("%0t: unexpected word status %0d value %0d count %0d last %0d", $realtime,
                 got_word.status, $signed(got_word.val), got_word.cnt, got_word.last);
      end else begin
        exp_word = awaited_words.pop_front();
        if (got_word !== exp_word) begin
          word_errors++;
          $display("%0t: expected status %0d value %0d count %0d last %0d", $realtime,
                   exp_word.status, $signed(exp_word.val), exp_word.cnt, exp_word.last);
          $display("%0t:   actual status %0d value %0d count %0d last %0d", $realtime,
                   got_word.status, $signed(got_word.val), got_word.cnt, got_word.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("ordered_list_engine_test: done, errors");
      $finish;
    end
  end

  initial begin
    int          n;
    int          r;
    logic [2:0]  op;
    logic [31:0] v;
    logic [4:0]  p;
    rst      <= 1'b1;
    start    <= 1'b0;
    cmd      <= oll_pkg::CMD_ADD_FRONT;
    value    <= 32'sd0;
    position <= 5'd0;

    add_row(oll_pkg::CMD_LIST, 32'd0, 5'd0, 5'd1, 1'b1, oll_pkg::ST_EMPTY, 5'd0);
    add_row(oll_pkg::CMD_DELETE, 32'd0, 5'd0, 5'd1, 1'b1, oll_pkg::ST_MISSING, 5'd0);
    add_row(oll_pkg::CMD_INSERT, 32'd1, 5'd1, 5'd1, 1'b1, oll_pkg::ST_POS, 5'd0);
    add_row(oll_pkg::CMD_INSERT, 32'd5, 5'd0, 5'd1, 1'b1, oll_pkg::ST_DONE, 5'd1);
    // delete the only entry, list goes empty
    add_row(oll_pkg::CMD_DELETE, 32'd5, 5'd0, 5'd1, 1'b1, oll_pkg::ST_DONE, 5'd0);
    add_row(oll_pkg::CMD_LIST, 32'd0, 5'd0, 5'd1, 1'b1, oll_pkg::ST_EMPTY, 5'd0);
    add_row(oll_pkg::CMD_ADD_FRONT, 32'h7fff_ffff, 5'd0, 5'd1, 1'b1, oll_pkg::ST_DONE, 5'd1);
    add_row(oll_pkg::CMD_ADD_FRONT, 32'h8000_0000, 5'd0, 5'd1, 1'b1, oll_pkg::ST_DONE, 5'd2);
    add_row(oll_pkg::CMD_ADD_BACK, 32'd0, 5'd0, 5'd1, 1'b1, oll_pkg::ST_DONE, 5'd3);
    // insert at a position equal to the count appends
    add_row(oll_pkg::CMD_INSERT, 32'hffff_ffff, 5'd3, 5'd1, 1'b1, oll_pkg::ST_DONE, 5'd4);
    add_row(oll_pkg::CMD_INSERT, 32'd7, 5'd0, 5'd1, 1'b1, oll_pkg::ST_DONE, 5'd5);
    add_row(oll_pkg::CMD_INSERT, 32'd9, 5'd31, 5'd1, 1'b1, oll_pkg::ST_POS, 5'd5);
    add_row(oll_pkg::CMD_LIST, 32'd0, 5'd0, 5'd1, 1'b0, oll_pkg::ST_DONE, 5'd0);
    add_row(oll_pkg::CMD_DELETE, 32'h8000_0000, 5'd0, 5'd1, 1'b1, oll_pkg::ST_DONE, 5'd4);
    add_row(oll_pkg::CMD_DELETE, 32'd12345, 5'd0, 5'd1, 1'b1, oll_pkg::ST_MISSING, 5'd4);
    // unused codes: accepted, no word back
    add_row(oll_pkg::CMD_LIST + 3'd1, 32'hffff_ffff, 5'd31, 5'd1, 1'b0, oll_pkg::ST_DONE, 5'd0);
    add_row(oll_pkg::CMD_LIST + 3'd2, 32'd0, 5'd0, 5'd1, 1'b0, oll_pkg::ST_DONE, 5'd0);
    add_row(oll_pkg::CMD_LIST + 3'd3, 32'h5a5a_a5a5, 5'd16, 5'd1, 1'b0, oll_pkg::ST_DONE, 5'd0);
    add_row(oll_pkg::CMD_ADD_BACK, 32'h5555_aaaa, 5'd0, 5'd12, 1'b0, oll_pkg::ST_DONE, 5'd0);
    // full store wins over a bad position
    add_row(oll_pkg::CMD_ADD_FRONT, 32'd3, 5'd0, 5'd1, 1'b1, oll_pkg::ST_FULL, 5'd16);
    add_row(oll_pkg::CMD_ADD_BACK, 32'd3, 5'd0, 5'd1, 1'b1, oll_pkg::ST_FULL, 5'd16);
    add_row(oll_pkg::CMD_INSERT, 32'd3, 5'd20, 5'd1, 1'b1, oll_pkg::ST_FULL, 5'd16);
    add_row(oll_pkg::CMD_LIST, 32'd0, 5'd0, 5'd1, 1'b0, oll_pkg::ST_DONE, 5'd0);
    add_row(oll_pkg::CMD_DELETE, 32'h5555_aaaa, 5'd0, 5'd1, 1'b1, oll_pkg::ST_DONE, 5'd15);
    add_row(oll_pkg::CMD_LIST, 32'd0, 5'd0, 5'd1, 1'b0, oll_pkg::ST_DONE, 5'd0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[k]) begin
      repeat (stim_rows[k].reps) begin
        send_cmd(stim_rows[k].op, stim_rows[k].val, stim_rows[k].pos);
        if (stim_rows[k].typed)
          awaited_words[awaited_words.size() - 1] =
            '{stim_rows[k].st, 32'd0, stim_rows[k].cnt, 1'b1};
      end
    end
    wait_drained();

    filling = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 62 : (ph == 3) ? 6 : 0;
      n = 0;
      while (n < RAND_PER_PHASE) begin
        while ($urandom_range(99) < idle_pct) pause_cycle();
        // swing between filling up and draining so both full and empty get hit
        if (held_entries.size() == 0) filling = 1'b1;
        else if (held_entries.size() >= oll_pkg::CAPACITY && $urandom_range(2) == 0)
          filling = 1'b0;
        else if ($urandom_range(39) == 0) filling = !filling;
        r = $urandom_range(99);
        if (r < (filling ? 70 : 25)) begin
          case (r % 3)
            0: op = oll_pkg::CMD_ADD_FRONT;
            1: op = oll_pkg::CMD_ADD_BACK;
            default: op = oll_pkg::CMD_INSERT;
          endcase
        end else if (r < (filling ? 85 : 75)) begin
          op = oll_pkg::CMD_DELETE;
        end else if (r < 97) begin
          op = oll_pkg::CMD_LIST;
        end else begin
          op = oll_pkg::CMD_LIST + 3'($urandom_range(1, 3));
        end
        v = pick_value();
        if (op == oll_pkg::CMD_DELETE && held_entries.size() != 0 && $urandom_range(4) != 0)
          v = held_entries[$urandom_range(held_entries.size() - 1)];
        p = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                     : 5'($urandom_range(held_entries.size()));
        send_cmd(op, v, p);
        if (op <= oll_pkg::CMD_LIST) n++;
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (word_errors == 0 && awaited_words.size() == 0) begin
      $display("ordered_list_engine_test: done, clean");
    end else begin
      $display("ordered_list_engine_test: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/oll_pkg.sv
rtl/oll_cell.sv
rtl/oll_ctrl.sv
rtl/ordered_list_engine.sv
verif/ordered_list_engine_test.sv
